// ===== rtl/delta_timeout_wait_queue_macros.svh =====
// assertion macros for the delta timeout wait queue
`ifndef DELTA_TIMEOUT_WAIT_QUEUE_MACROS_SVH
`define DELTA_TIMEOUT_WAIT_QUEUE_MACROS_SVH
// implication check under synchronous reset
`define DTWQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check under synchronous reset
`define DTWQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/dtwq_pkg.sv =====
// package: types and constants of the delta timeout wait queue
package dtwq_pkg;
  localparam int QueueDepth = 16;
  localparam int TaskIdBits = 8;
  localparam int TickBits = 24;
  localparam int CountBits = $clog2(QueueDepth + 1);
  localparam int IdxBits = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_WAKE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_INSERTED = 3'd0,
    EV_REJECTED = 3'd1,
    EV_REMOVED  = 3'd2,
    EV_NOTFOUND = 3'd3,
    EV_EXPIRED  = 3'd4,
    EV_WOKEN    = 3'd5,
    EV_NOTHING  = 3'd6
  } event_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [TaskIdBits-1:0] task_id;
    logic [TickBits-1:0]   timeout_ticks;
  } in_word_t;

  typedef struct packed {
    logic [TaskIdBits-1:0] out_task;
    logic [2:0]            event_res;
    logic                  last;
  } out_word_t;
endpackage

// ===== rtl/delta_timeout_wait_queue.sv =====
// Delta timeout wait queue: a request word enters a two-word queue and is
// carried out by a sequencer over a delta list of 16 cells. Each request goes
// through a take step, a prefix-sum scan over the cells, an apply step and an
// emit step, in that order; a wake of the whole queue gives one result per
// queued task, with an apply and an emit step for each. Output stalls hold the
// emit step, and the sequencer takes no new request until its last result word
// has left. The config register wake_one resets to 1.
module delta_timeout_wait_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtwq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtwq_pkg::out_word_t out_data
);
  logic               wake_one;
  logic               req_valid;
  logic               req_take;
  dtwq_pkg::in_word_t req_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_one <= 1'b1;
    end else if (cfg_we) begin
      wake_one <= cfg_data;
    end
  end

  dtwq_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_data),
    .req_valid(req_valid), .req_take(req_take), .req_word(req_word)
  );

  dtwq_back u_back (
    .clk(clk), .rst(rst), .wake_one(wake_one), .req_valid(req_valid),
    .req_take(req_take), .req_word(req_word), .out_valid(out_valid),
    .out_stall(out_stall), .out_word(out_data)
  );
endmodule

// ===== rtl/dtwq_front.sv =====
// front part: two-entry request queue
module dtwq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtwq_pkg::in_word_t  in_word,
  output logic                req_valid,
  input  logic                req_take,
  output dtwq_pkg::in_word_t  req_word
);
  dtwq_pkg::in_word_t slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign req_valid = (fill != 2'd0);
  assign pop       = req_valid && req_take;
  assign req_word  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_word;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/dtwq_back.sv =====
// back part: delta list of cells and the sequencer that edits it
`include "delta_timeout_wait_queue_macros.svh"
module dtwq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                wake_one,
  input  logic                req_valid,
  output logic                req_take,
  input  dtwq_pkg::in_word_t  req_word,
  output logic                out_valid,
  input  logic                out_stall,
  output dtwq_pkg::out_word_t out_word
);
  localparam int Depth = dtwq_pkg::QueueDepth;
  localparam int Tb = dtwq_pkg::TickBits;
  localparam int Cb = dtwq_pkg::CountBits;
  localparam int Ib = dtwq_pkg::IdxBits;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  logic [dtwq_pkg::TaskIdBits-1:0] cell_task [Depth];
  logic [Tb-1:0] cell_delta [Depth];
  logic [Cb-1:0] count;
  dtwq_pkg::in_word_t req;

  logic [Depth-1:0] live;
  logic [Depth-1:0] hit;
  logic [Tb:0]      cum [Depth];
  logic [Depth-1:0] hit_r;
  logic [Depth-1:0] later_r;
  logic [Tb:0]      cum_r [Depth];
  logic             found;
  logic [Ib-1:0]    hit_pos;
  logic [Cb-1:0]    ins_pos;
  logic             full_out;
  logic             more;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      live[i] = (Cb'(i) < count);
      hit[i]  = live[i] && (cell_task[i] == req.task_id);
      cum[i]  = {1'b0, cell_delta[i]};
    end
  end

  // running sums are registered partial sums: cum_r holds the deadline of each cell
  always_comb begin
    found   = |hit_r;
    hit_pos = '0;
    ins_pos = count;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (hit_r[i]) hit_pos = Ib'(i);
      if (later_r[i]) ins_pos = Cb'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      hit_r <= hit;
      for (int i = 0; i < Depth; i++) begin
        later_r[i] <= live[i] && (cum_r[i] > {1'b0, req.timeout_ticks});
      end
    end
  end

  // prefix sums: a chain of registers, each cell adding its delta to the sum of the cell before
  always_ff @(posedge clk) begin
    cum_r[0] <= cum[0];
    for (int i = 1; i < Depth; i++) begin
      cum_r[i] <= cum_r[i-1] + cum[i];
    end
  end

  logic [Ib:0] wait_cnt;

  assign req_take  = (state == S_IDLE) && req_valid;
  assign out_valid = (state == S_EMIT);
  assign full_out  = (count == Cb'(Depth));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req      <= req_word;
            wait_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == (Ib+1)'(Depth - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          case (dtwq_pkg::action_t'(req.action))
            dtwq_pkg::ACT_INSERT: begin
              out_word.last     <= 1'b1;
              out_word.out_task <= req.task_id;
              if (full_out || found) begin
                out_word.event_res <= dtwq_pkg::EV_REJECTED;
              end else begin
                out_word.event_res <= dtwq_pkg::EV_INSERTED;
                for (int i = Depth - 1; i >= 1; i--) begin
                  if (Cb'(i) > ins_pos && Cb'(i) <= count) begin
                    cell_task[i] <= cell_task[i-1];
                  end
                  if (Cb'(i) > ins_pos + 1'b1 && Cb'(i) <= count) begin
                    cell_delta[i] <= cell_delta[i-1];
                  end
                end
                cell_task[ins_pos[Ib-1:0]] <= req.task_id;
                cell_delta[ins_pos[Ib-1:0]] <= (ins_pos == '0) ? req.timeout_ticks :
                  req.timeout_ticks - cum_r[Ib'(ins_pos - 1'b1)][Tb-1:0];
                if (ins_pos != count) begin
                  cell_delta[Ib'(ins_pos + 1'b1)] <= cum_r[ins_pos[Ib-1:0]][Tb-1:0]
                    - req.timeout_ticks;
                end
                count <= count + 1'b1;
              end
            end
            dtwq_pkg::ACT_REMOVE: begin
              out_word.last     <= 1'b1;
              out_word.out_task <= req.task_id;
              if (found) begin
                out_word.event_res <= dtwq_pkg::EV_REMOVED;
                for (int i = 0; i < Depth - 1; i++) begin
                  if (Ib'(i) >= hit_pos) begin
                    cell_task[i] <= cell_task[i+1];
                    if (Ib'(i) == hit_pos) begin
                      cell_delta[i] <= cell_delta[i] + cell_delta[i+1];
                    end else begin
                      cell_delta[i] <= cell_delta[i+1];
                    end
                  end
                end
                count <= count - 1'b1;
              end else begin
                out_word.event_res <= dtwq_pkg::EV_NOTFOUND;
              end
            end
            dtwq_pkg::ACT_TICK: begin
              out_word.last <= 1'b1;
              if (count != '0 && cell_delta[0] <= Tb'(1)) begin
                out_word.out_task  <= cell_task[0];
                out_word.event_res <= dtwq_pkg::EV_EXPIRED;
                for (int i = 0; i < Depth - 1; i++) begin
                  cell_task[i]  <= cell_task[i+1];
                  cell_delta[i] <= cell_delta[i+1];
                end
                count <= count - 1'b1;
              end else begin
                out_word.out_task  <= '0;
                out_word.event_res <= dtwq_pkg::EV_NOTHING;
                if (count != '0) cell_delta[0] <= cell_delta[0] - 1'b1;
              end
            end
            default: begin
              if (count != '0) begin
                out_word.out_task  <= cell_task[0];
                out_word.event_res <= dtwq_pkg::EV_WOKEN;
                out_word.last      <= wake_one || (count == Cb'(1));
                for (int i = 0; i < Depth - 1; i++) begin
                  cell_task[i] <= cell_task[i+1];
                end
                cell_delta[0] <= cell_delta[0] + cell_delta[1];
                for (int i = 1; i < Depth - 1; i++) begin
                  cell_delta[i] <= cell_delta[i+1];
                end
                count <= count - 1'b1;
              end else begin
                out_word.out_task  <= '0;
                out_word.event_res <= dtwq_pkg::EV_NOTHING;
                out_word.last      <= 1'b1;
              end
            end
          endcase
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            state <= more ? S_APPLY : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign more = !out_word.last;

  `DTWQ_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= Cb'(Depth))
  `DTWQ_ASSERT_IMP(a_no_take_busy, clk, rst, state != S_IDLE, !req_take)
  `DTWQ_ASSERT_NXT(a_emit_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule

// ===== test/dtwq_checker.sv =====
// checker: predicts the delta timeout wait queue and compares its result words
module dtwq_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  dtwq_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  dtwq_pkg::out_word_t out_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Ab = dtwq_pkg::TaskIdBits;
  localparam int Tb = dtwq_pkg::TickBits;
  localparam int Depth = dtwq_pkg::QueueDepth;

  logic [Ab-1:0]       q_task[Depth];
  logic [Tb-1:0]       q_delta[Depth];
  int                  q_count;
  logic                wake_all_off;
  dtwq_pkg::out_word_t expected_words[$];

  assign pending = expected_words.size();

  task automatic report(input string what, input dtwq_pkg::out_word_t got,
                        input dtwq_pkg::out_word_t want);
    $display("mismatch %s: got task %0d ev %0d last %0d, want task %0d ev %0d last %0d",
             what, got.out_task, got.event_res, got.last,
             want.out_task, want.event_res, want.last);
    errors++;
  endtask

  function automatic void take_out(input int pos);
    if (pos + 1 < q_count) q_delta[pos+1] = q_delta[pos+1] + q_delta[pos];
    for (int i = pos; i + 1 < q_count; i++) begin
      q_task[i] = q_task[i+1];
      q_delta[i] = q_delta[i+1];
    end
    q_count--;
  endfunction

  function automatic int find_task(input logic [Ab-1:0] t);
    for (int i = 0; i < q_count; i++) if (q_task[i] == t) return i;
    return -1;
  endfunction

  function automatic void push(input logic [Ab-1:0] t, input dtwq_pkg::event_t ev);
    dtwq_pkg::out_word_t w;
    w.out_task = t;
    w.event_res = ev;
    w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_queue(input dtwq_pkg::in_word_t w);
    longint cum, prev;
    int pos;
    logic [Tb-1:0] d, head;
    case (dtwq_pkg::action_t'(w.action))
      dtwq_pkg::ACT_INSERT: begin
        if (q_count >= Depth || find_task(w.task_id) >= 0) begin
          push(w.task_id, dtwq_pkg::EV_REJECTED);
        end else begin
          cum = 0; prev = 0; pos = q_count;
          for (int i = 0; i < q_count; i++) begin
            prev = cum;
            cum += q_delta[i];
            if (cum > w.timeout_ticks) begin
              pos = i;
              break;
            end
          end
          if (pos < q_count) begin
            d = Tb'(w.timeout_ticks - prev);
            q_delta[pos] = q_delta[pos] - d;
          end else begin
            d = Tb'(w.timeout_ticks - cum);
          end
          for (int i = q_count; i > pos; i--) begin
            q_task[i] = q_task[i-1];
            q_delta[i] = q_delta[i-1];
          end
          q_task[pos] = w.task_id;
          q_delta[pos] = d;
          q_count++;
          push(w.task_id, dtwq_pkg::EV_INSERTED);
        end
      end
      dtwq_pkg::ACT_REMOVE: begin
        pos = find_task(w.task_id);
        if (pos >= 0) begin
          take_out(pos);
          push(w.task_id, dtwq_pkg::EV_REMOVED);
        end else begin
          push(w.task_id, dtwq_pkg::EV_NOTFOUND);
        end
      end
      dtwq_pkg::ACT_TICK: begin
        if (q_count == 0) begin
          push('0, dtwq_pkg::EV_NOTHING);
        end else begin
          head = q_delta[0];
          q_delta[0] = (head != '0) ? head - 1'b1 : '0;
          if (head <= Tb'(1)) begin
            push(q_task[0], dtwq_pkg::EV_EXPIRED);
            take_out(0);
          end else begin
            push('0, dtwq_pkg::EV_NOTHING);
          end
        end
      end
      default: begin
        if (q_count == 0) begin
          push('0, dtwq_pkg::EV_NOTHING);
        end else begin
          do begin
            push(q_task[0], dtwq_pkg::EV_WOKEN);
            take_out(0);
          end while (wake_all_off && q_count > 0);
        end
      end
    endcase
    expected_words[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      q_count = 0;
      wake_all_off = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_we) wake_all_off = !cfg_data;
      if (in_valid && !in_stall) predict_queue(in_data);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", out_data, '0);
        end else begin
          if (out_data !== expected_words[0]) report("field", out_data, expected_words[0]);
          void'(expected_words.pop_front());
        end
      end
    end
  end

  initial errors = 0;
endmodule

// ===== test/testbench.sv =====
// testbench top: stimulus for the delta timeout wait queue and the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Ab = dtwq_pkg::TaskIdBits;
  localparam int Tb = dtwq_pkg::TickBits;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_data = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dtwq_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dtwq_pkg::out_word_t out_data;
  int                  errors, pending;
  int                  send_idle = 0, recv_stall = 0;
  longint              cycles = 0;
  logic [Ab-1:0]       pool[8];

  delta_timeout_wait_queue dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  dtwq_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(99) < recv_stall);
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high after acceptance until the next idle cycle or a drain
  task automatic send_word(input dtwq_pkg::action_t a, input logic [Ab-1:0] t,
                           input logic [Tb-1:0] ticks);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {a, t, ticks};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_wake_one(input logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int r;
    logic [Tb-1:0] ticks;
    r = $urandom_range(99);
    ticks = ($urandom_range(9) == 0) ? Tb'($urandom()) : Tb'($urandom_range(12));
    if (r < 45) send_word(dtwq_pkg::ACT_INSERT, pool[3'($urandom_range(7))], ticks);
    else if (r < 55) send_word(dtwq_pkg::ACT_INSERT, Ab'($urandom()), Tb'($urandom()));
    else if (r < 65) send_word(dtwq_pkg::ACT_REMOVE, pool[3'($urandom_range(7))],
                               Tb'($urandom()));
    else if (r < 70) send_word(dtwq_pkg::ACT_REMOVE, Ab'($urandom()), Tb'($urandom()));
    else if (r < 93) send_word(dtwq_pkg::ACT_TICK, Ab'($urandom()), Tb'($urandom()));
    else send_word(dtwq_pkg::ACT_WAKE, Ab'($urandom()), Tb'($urandom()));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) pool[i] = Ab'($urandom());
    pool[0] = '0;
    pool[1] = '1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: fill past full, duplicate, remove, ticks, wakes
    send_word(dtwq_pkg::ACT_TICK, '0, '0);
    send_word(dtwq_pkg::ACT_WAKE, '1, '1);
    send_word(dtwq_pkg::ACT_INSERT, 8'd0, 24'hffffff);
    send_word(dtwq_pkg::ACT_INSERT, 8'd255, 24'd0);
    send_word(dtwq_pkg::ACT_INSERT, 8'd255, 24'd5);
    for (int i = 1; i <= 15; i++) send_word(dtwq_pkg::ACT_INSERT, Ab'(i), Tb'((i * 3) % 7));
    send_word(dtwq_pkg::ACT_REMOVE, 8'd3, '0);
    send_word(dtwq_pkg::ACT_REMOVE, 8'd200, '0);
    send_word(dtwq_pkg::ACT_TICK, '0, '0);
    send_word(dtwq_pkg::ACT_TICK, '0, '0);
    send_word(dtwq_pkg::ACT_WAKE, '0, '0);
    set_wake_one(1'b0);
    send_word(dtwq_pkg::ACT_WAKE, '0, '0);
    set_wake_one(1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 63 : 30) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 63 : 30) : 0;
      for (int n = 0; n < 70; n++) random_word();
      set_wake_one(ph[0]);
    end
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
